// ===== rtl/lzw_pkg.sv =====
`timescale 1ns / 1ps
package lzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_DEPTH   = 8192;

    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int NEXT_W  = MAX_CODE_BITS + 1;
    localparam int WIDTH_W = $clog2(MAX_CODE_BITS + 1);
    localparam int TBL_AW  = $clog2(TABLE_DEPTH);
    localparam int KEY_W   = CODE_W + 8;
    localparam int PROD_W  = TBL_AW + 13;
    localparam int ACC_W   = 7 + MAX_CODE_BITS;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    localparam logic [15:0]        HASH_MULT  = 16'd40503;
    localparam logic [NEXT_W-1:0]  CODE_INIT  = NEXT_W'(256);
    localparam logic [WIDTH_W-1:0] WIDTH_INIT = WIDTH_W'(9);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic [2:0] pad_count;
        logic       stream_end;
    } out_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] prefix;
        logic [7:0]        dbyte;
        logic [CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_ADDR,
        ST_READ,
        ST_CHECK,
        ST_EMIT,
        ST_TAIL,
        ST_FEMIT,
        ST_PAD,
        ST_WIPE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic take_first;
        logic mul_key;
        logic load_slot;
        logic rd_en;
        logic probe_next;
        logic take_hit;
        logic miss;
        logic ins_ok;
        logic load_flush;
        logic emit_byte;
        logic emit_end;
        logic save_tail;
        logic emit_pad;
        logic wipe;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic pvalid;
        logic final_b;
        logic hit;
        logic empty;
        logic probe_last;
        logic n_ge8;
        logic n_eq8;
        logic n_zero;
        logic out_free;
        logic clr_last;
    } stat_t;

endpackage

// ===== rtl/lzw_ram.sv =====
`timescale 1ns / 1ps
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/lzw_datapath.sv =====
`timescale 1ns / 1ps
module lzw_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  lzw_pkg::in_t   s_payload,
    input  lzw_pkg::cmd_t  cmd,
    output lzw_pkg::stat_t stat,
    output logic           m_valid,
    input  logic           m_ready,
    output lzw_pkg::out_t  m_payload
);
    import lzw_pkg::*;

    logic [7:0]         byte_reg;
    logic               final_reg;
    logic [CODE_W-1:0]  prefix_reg;
    logic               pvalid_reg;
    logic [NEXT_W-1:0]  next_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [6:0]         hold_reg;
    logic [2:0]         fill_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TBL_AW-1:0]  slot_reg;
    logic [TBL_AW-1:0]  probe_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [TBL_AW-1:0]  clr_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    entry_t             rd_entry;
    entry_t             wr_entry;
    logic [ENTRY_W-1:0] rdata;
    logic               ram_we;
    logic [TBL_AW-1:0]  ram_waddr;
    logic               can_learn;
    logic [NEXT_W-1:0]  next_inc;
    logic [CODE_W-1:0]  code_mask;
    logic [ACC_W-1:0]   acc_load;
    logic [CNT_W-1:0]   n_load;
    logic [TBL_AW-1:0]  hash;
    logic [KEY_W-1:0]   key;
    logic [ACC_W-1:0]   acc_shift;
    logic [2:0]         pad;
    logic [7:0]         pad_byte;

    assign rd_entry  = entry_t'(rdata);
    assign key       = {prefix_reg, byte_reg};
    assign hash      = prod_reg[TBL_AW-1:0] ^ prod_reg[TBL_AW+12:13];
    assign can_learn = !next_reg[MAX_CODE_BITS];
    assign next_inc  = next_reg + NEXT_W'(1);
    assign code_mask = ~({CODE_W{1'b1}} << width_reg);
    assign acc_load  = (ACC_W'(hold_reg) << width_reg) | ACC_W'(prefix_reg & code_mask);
    assign n_load    = CNT_W'(fill_reg) + CNT_W'(width_reg);
    assign acc_shift = acc_reg >> (n_reg - CNT_W'(8));
    assign pad       = 3'(4'd8 - {1'b0, n_reg[2:0]});
    assign pad_byte  = 8'(acc_reg[7:0] << pad);

    assign wr_entry  = '{valid: 1'b1, prefix: prefix_reg, dbyte: byte_reg,
                         code: next_reg[CODE_W-1:0]};
    assign ram_we    = cmd.clear_step || (cmd.miss && cmd.ins_ok && can_learn);
    assign ram_waddr = cmd.clear_step ? clr_reg : slot_reg;

    lzw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.clear_step ? '0 : ENTRY_W'(wr_entry)),
        .re    (cmd.rd_en),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.wipe) begin
            pvalid_reg <= 1'b0;
            next_reg   <= CODE_INIT;
            width_reg  <= WIDTH_INIT;
            hold_reg   <= '0;
            fill_reg   <= '0;
            clr_reg    <= '0;
        end else begin
            if (cmd.take_first) begin
                pvalid_reg <= 1'b1;
            end
            if (cmd.miss && cmd.ins_ok && can_learn) begin
                next_reg <= next_inc;
                if (((next_inc >> width_reg) != '0) &&
                    (width_reg < WIDTH_W'(MAX_CODE_BITS))) begin
                    width_reg <= width_reg + WIDTH_W'(1);
                end
            end
            if (cmd.save_tail) begin
                hold_reg <= acc_reg[6:0] & ~(7'h7f << n_reg[2:0]);
                fill_reg <= n_reg[2:0];
            end
            if (cmd.clear_step) begin
                clr_reg <= clr_reg + TBL_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_byte || cmd.emit_pad) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            byte_reg  <= s_payload.data_byte;
            final_reg <= s_payload.final_byte;
        end
        if (cmd.take_first) begin
            prefix_reg <= CODE_W'(byte_reg);
        end else if (cmd.take_hit) begin
            prefix_reg <= rd_entry.code;
        end else if (cmd.miss) begin
            prefix_reg <= CODE_W'(byte_reg);
        end
        if (cmd.mul_key) begin
            prod_reg <= PROD_W'(PROD_W'(key) * PROD_W'(HASH_MULT));
        end
        if (cmd.load_slot) begin
            slot_reg  <= hash;
            probe_reg <= '0;
        end else if (cmd.probe_next) begin
            slot_reg  <= slot_reg + TBL_AW'(1);
            probe_reg <= probe_reg + TBL_AW'(1);
        end
        if (cmd.miss || cmd.load_flush) begin
            acc_reg <= acc_load;
            n_reg   <= n_load;
        end else if (cmd.emit_byte) begin
            n_reg <= n_reg - CNT_W'(8);
        end
        if (cmd.emit_byte) begin
            m_data_reg <= '{packed_byte: acc_shift[7:0], pad_count: 3'd0,
                            stream_end: cmd.emit_end};
        end else if (cmd.emit_pad) begin
            m_data_reg <= '{packed_byte: pad_byte, pad_count: pad, stream_end: 1'b1};
        end
    end

    assign stat.pvalid     = pvalid_reg;
    assign stat.final_b    = final_reg;
    assign stat.hit        = rd_entry.valid && (rd_entry.prefix == prefix_reg) &&
                             (rd_entry.dbyte == byte_reg);
    assign stat.empty      = !rd_entry.valid;
    assign stat.probe_last = (probe_reg == {TBL_AW{1'b1}});
    assign stat.n_ge8      = (n_reg >= CNT_W'(8));
    assign stat.n_eq8      = (n_reg == CNT_W'(8));
    assign stat.n_zero     = (n_reg == '0);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.clr_last   = (clr_reg == {TBL_AW{1'b1}});

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;
endmodule

// ===== rtl/lzw_ctrl.sv =====
`timescale 1ns / 1ps
module lzw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lzw_pkg::stat_t stat,
    output lzw_pkg::cmd_t  cmd
);
    import lzw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_START;
            ST_START: state_next = stat.pvalid ? ST_ADDR : ST_TAIL;
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (stat.hit) begin
                    state_next = ST_TAIL;
                end else if (stat.empty || stat.probe_last) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:  if (!stat.n_ge8) state_next = ST_TAIL;
            ST_TAIL:  state_next = stat.final_b ? ST_FEMIT : ST_IDLE;
            ST_FEMIT: begin
                if (!stat.n_ge8) begin
                    state_next = stat.n_zero ? ST_WIPE : ST_PAD;
                end
            end
            ST_PAD:   if (stat.out_free) state_next = ST_WIPE;
            ST_WIPE:  state_next = ST_CLEAR;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            ST_START: begin
                cmd.take_first = !stat.pvalid;
                cmd.mul_key    = stat.pvalid;
            end
            ST_ADDR:  cmd.load_slot = 1'b1;
            ST_READ:  cmd.rd_en = 1'b1;
            ST_CHECK: begin
                cmd.take_hit   = stat.hit;
                cmd.miss       = !stat.hit && (stat.empty || stat.probe_last);
                cmd.ins_ok     = stat.empty;
                cmd.probe_next = !stat.hit && !stat.empty && !stat.probe_last;
            end
            ST_EMIT: begin
                cmd.emit_byte = stat.n_ge8 && stat.out_free;
                cmd.save_tail = !stat.n_ge8;
            end
            ST_TAIL:  cmd.load_flush = stat.final_b;
            ST_FEMIT: begin
                cmd.emit_byte = stat.n_ge8 && stat.out_free;
                cmd.emit_end  = stat.n_eq8;
            end
            ST_PAD:   cmd.emit_pad = stat.out_free;
            ST_WIPE:  cmd.wipe = 1'b1;
            default:  cmd = '0;
        endcase
    end
endmodule

// ===== rtl/lzw_byte_compressor.sv =====
`timescale 1ns / 1ps
// LZW byte compressor with variable-width codes (9 up to 12 bits).
// Input channel s_*: one uncompressed byte per transaction; final_byte marks
// the last byte of a stream. Output channel m_*: packed code bytes, MSB first.
// The last byte of a stream carries stream_end = 1 and, if it was padded,
// the number of zero pad bits in pad_count.
// Throughput: one byte at a time. A byte that extends the match steps through
// accept, hash multiply, slot address, table read, compare and tail; each
// extra linear probe repeats the table read and compare. A miss adds the emit
// step, which sends each whole output byte and then keeps the leftover bits.
// The loop through the 8192-entry match table's single read port sets this.
// The first byte of a stream emits nothing unless it is also the final byte.
// Reset and end of stream: the match table is swept clean, one entry a
// cycle, through all 8192 entries after reset and after each final byte;
// s_ready stays low during the sweep.
// A stalled receiver holds the output register; the block waits in its
// emit step until the pending transaction is taken, losing nothing.
module lzw_byte_compressor (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lzw_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output lzw_pkg::out_t m_payload
);
    import lzw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: walks each byte through hash, probe, emit and flush
    lzw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table, prefix/code state, bit packer and output register
    lzw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // never overwrite a result still waiting for the receiver
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_byte || cmd.emit_pad) |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    // pad count only shows on the end-of-stream transaction
    a_pad_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.stream_end) |-> (m_payload.pad_count == 3'd0))
        else $error("pad count on non-final byte");

    // no input taken while the table sweep runs
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_ready)
        else $error("input accepted during table sweep");
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the LZW byte compressor.
// A driver at the falling edge feeds bytes from a queue; a monitor at the
// rising edge runs a local LZW model on every accepted input transaction and
// compares each accepted output transaction against the oldest predicted byte.
module tb_top;
    import lzw_pkg::*;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_payload = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_payload;

    lzw_byte_compressor DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Pending input bytes and predicted packed bytes.
    in_t  byte_queue[$];
    out_t packed_queue[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic in_taken = 1'b0;

    // Local dictionary model.
    logic        dict_valid [TABLE_DEPTH];
    logic [11:0] dict_prefix[TABLE_DEPTH];
    logic [7:0]  dict_byte  [TABLE_DEPTH];
    logic [11:0] dict_code  [TABLE_DEPTH];
    int unsigned cur_prefix;
    bit          have_prefix;
    int unsigned free_code;
    int unsigned cur_width;
    int unsigned hold_bits;
    int unsigned hold_fill;

    function automatic void dict_clear();
        for (int i = 0; i < TABLE_DEPTH; i++) dict_valid[i] = 1'b0;
        cur_prefix = 0;
        have_prefix = 0;
        free_code = 256;
        cur_width = 9;
        hold_bits = 0;
        hold_fill = 0;
    endfunction

    function automatic int unsigned slot_of(int unsigned pfx, int unsigned b);
        logic [31:0] h;
        h = ((pfx << 8) | b) * 32'd40503;
        h = h ^ (h >> 13);
        return h % TABLE_DEPTH;
    endfunction

    // Append one code and queue every whole byte it completes.
    function automatic void pack_code(int unsigned code);
        longint unsigned acc;
        int unsigned n;
        out_t o;
        acc = (longint'(hold_bits) << cur_width) | (code & ((1 << cur_width) - 1));
        n = hold_fill + cur_width;
        while (n >= 8) begin
            o.packed_byte = 8'(acc >> (n - 8));
            o.pad_count = '0;
            o.stream_end = 1'b0;
            packed_queue.push_back(o);
            n -= 8;
        end
        hold_bits = int'(acc & ((1 << n) - 1));
        hold_fill = n;
    endfunction

    function automatic void compress_byte(in_t item);
        int unsigned idx, slot, pad;
        int unsigned q_start;
        bit hit;
        out_t o;
        q_start = packed_queue.size();
        if (!have_prefix) begin
            cur_prefix = item.data_byte;
            have_prefix = 1;
        end else begin
            idx = slot_of(cur_prefix, item.data_byte);
            hit = 0;
            slot = TABLE_DEPTH;
            for (int p = 0; p < TABLE_DEPTH; p++) begin
                if (!dict_valid[idx]) begin
                    slot = idx;
                    break;
                end
                if (dict_prefix[idx] == cur_prefix && dict_byte[idx] == item.data_byte) begin
                    hit = 1;
                    break;
                end
                idx = (idx + 1) % TABLE_DEPTH;
            end
            if (hit) begin
                cur_prefix = dict_code[idx];
            end else begin
                pack_code(cur_prefix);
                if (free_code < (1 << MAX_CODE_BITS) && slot < TABLE_DEPTH) begin
                    dict_valid[slot] = 1'b1;
                    dict_prefix[slot] = 12'(cur_prefix);
                    dict_byte[slot] = item.data_byte;
                    dict_code[slot] = 12'(free_code);
                    free_code++;
                    if (free_code >= (1 << cur_width) && cur_width < MAX_CODE_BITS)
                        cur_width++;
                end
                cur_prefix = item.data_byte;
            end
        end
        if (item.final_byte) begin
            pack_code(cur_prefix);
            pad = (8 - hold_fill) & 7;
            if (hold_fill != 0) begin
                o.packed_byte = 8'(hold_bits << pad);
                o.pad_count = 3'(pad);
                o.stream_end = 1'b1;
                packed_queue.push_back(o);
            end else if (packed_queue.size() > q_start) begin
                packed_queue[packed_queue.size() - 1].stream_end = 1'b1;
            end
            dict_clear();
        end
    endfunction

    // Driver: hold valid and payload until the transaction is taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_payload <= byte_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge aclk) begin
        out_t want;
        in_taken <= s_valid && s_ready && aresetn;
        if (aresetn) begin
            if (s_valid && s_ready) compress_byte(s_payload);
            if (m_valid && m_ready) begin
                if (packed_queue.size() == 0) begin
                    $display("%0t: unexpected output byte %h pad %0d end %0b", $time,
                             m_payload.packed_byte, m_payload.pad_count,
                             m_payload.stream_end);
                    errors++;
                end else begin
                    want = packed_queue.pop_front();
                    if (want != m_payload) begin
                        $display("%0t: expected byte %h pad %0d end %0b, got %h pad %0d end %0b",
                                 $time, want.packed_byte, want.pad_count, want.stream_end,
                                 m_payload.packed_byte, m_payload.pad_count,
                                 m_payload.stream_end);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic add_stream(int len, int alphabet);
        in_t it;
        for (int i = 0; i < len; i++) begin
            it.data_byte = (alphabet >= 256) ? 8'($urandom) : 8'($urandom_range(alphabet - 1));
            if ($urandom_range(3) == 0) it.data_byte = ~it.data_byte;
            it.final_byte = (i == len - 1);
            byte_queue.push_back(it);
        end
    endtask

    task automatic add_byte(logic [7:0] b, logic fin);
        in_t it;
        it.data_byte = b;
        it.final_byte = fin;
        byte_queue.push_back(it);
    endtask

    task automatic drain();
        while (byte_queue.size() > 0 || s_valid || packed_queue.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        dict_clear();
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed: single-byte streams at both extremes.
        add_byte(8'h00, 1'b1);
        add_byte(8'hff, 1'b1);
        // Eight distinct codes of 9 bits end on a byte boundary.
        for (int i = 0; i < 8; i++) add_byte(8'(i), i == 7);
        // Repeats build long matches.
        for (int i = 0; i < 14; i++) add_byte((i % 2) ? 8'hff : 8'h00, i == 13);
        drain();

        // A longer random stream.
        add_stream(60, 256);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            add_stream($urandom_range(1, 40), 256);
            add_stream($urandom_range(1, 20), $urandom_range(1, 4));
            drain();
        end

        repeat (200) @(posedge aclk);
        if (errors == 0 && packed_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
